@@ hw/rtl/ffa_pkg.sv @@
// Package for the first-fit allocator: shared constants, codes and the
// controller-to-datapath command and status structs. No dependencies.
package ffa_pkg;

  localparam int unsigned FreeSlotsDef   = 16;
  localparam int unsigned LiveSlotsDef   = 16;
  localparam int unsigned HeaderBytesDef = 8;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 25;
  localparam int unsigned ReqW  = 24;
  localparam int unsigned LiveW = 5;
  localparam int unsigned StatW = 3;

  localparam logic [StatW-1:0] ST_OK      = 3'd0;
  localparam logic [StatW-1:0] ST_NOFIT   = 3'd1;
  localparam logic [StatW-1:0] ST_FREEFUL = 3'd2;
  localparam logic [StatW-1:0] ST_RECFUL  = 3'd3;
  localparam logic [StatW-1:0] ST_UNKNOWN = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RSCAN, S_ASCAN, S_ACHECK, S_ATAKE, S_FSCAN, S_FPOS, S_FDECIDE,
    S_SHIFT, S_COMMIT, S_OUT
  } state_t;

  // Commands from the controller.
  typedef struct packed {
    logic load;        // latch the item
    logic rec_step;    // advance the record pointer
    logic ext_step;    // advance the extent pointer
    logic eval;        // register fit / merge evaluation
    logic alloc_take;  // update extent table for allocate
    logic free_apply;  // update extent table for free
    logic shift_step;  // move one extent entry
    logic commit;      // update records and totals
    logic [StatW-1:0] status;
    logic set_status;
  } cmd_t;

  typedef struct packed {
    logic cmd;         // latched command of the item in work
    logic rec_hit;     // current record matches (free free slot or address)
    logic rec_end;     // record pointer at last slot
    logic ext_end;     // extent pointer past count
    logic fit;         // registered fit result
    logic pos_stop;    // extent start >= block end
    logic merge_any;   // free merges with a neighbor
    logic table_full;  // extent count at capacity
    logic shift_done;  // no shifting left
    logic req_zero;
  } stat_t;

endpackage

@@ hw/rtl/ffa_ctrl.sv @@
// Controller state machine of the allocator.
// Depends on ffa_pkg.
module ffa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_fire,
  input  logic                cfg_we,
  input  ffa_pkg::stat_t      st,
  output ffa_pkg::cmd_t       cm,
  output logic                busy,
  output logic                out_valid
);

  ffa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cm = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cm.load = 1'b1;
          state_nxt = ffa_pkg::S_RSCAN;
        end
      end
      ffa_pkg::S_RSCAN: begin
        if (st.cmd == ffa_pkg::CMD_ALLOC && st.req_zero) begin
          cm.set_status = 1'b1;
          cm.status = ffa_pkg::ST_NOFIT;
          state_nxt = ffa_pkg::S_OUT;
        end else if (st.rec_hit) begin
          state_nxt = (st.cmd == ffa_pkg::CMD_ALLOC) ? ffa_pkg::S_ASCAN
                                                     : ffa_pkg::S_FSCAN;
        end else if (st.rec_end) begin
          cm.set_status = 1'b1;
          cm.status = (st.cmd == ffa_pkg::CMD_ALLOC) ? ffa_pkg::ST_RECFUL
                                                     : ffa_pkg::ST_UNKNOWN;
          state_nxt = ffa_pkg::S_OUT;
        end else begin
          cm.rec_step = 1'b1;
        end
      end
      ffa_pkg::S_ASCAN: begin
        if (st.ext_end) begin
          cm.set_status = 1'b1;
          cm.status = ffa_pkg::ST_NOFIT;
          state_nxt = ffa_pkg::S_OUT;
        end else begin
          cm.eval = 1'b1;
          state_nxt = ffa_pkg::S_ACHECK;
        end
      end
      ffa_pkg::S_ACHECK: begin
        if (st.fit) begin
          state_nxt = ffa_pkg::S_ATAKE;
        end else begin
          cm.ext_step = 1'b1;
          state_nxt = ffa_pkg::S_ASCAN;
        end
      end
      ffa_pkg::S_ATAKE: begin
        cm.alloc_take = 1'b1;
        state_nxt = ffa_pkg::S_SHIFT;
      end
      ffa_pkg::S_FSCAN: begin
        if (st.ext_end || st.pos_stop) begin
          cm.eval = 1'b1;
          state_nxt = ffa_pkg::S_FPOS;
        end else begin
          cm.ext_step = 1'b1;
        end
      end
      ffa_pkg::S_FPOS: begin
        state_nxt = ffa_pkg::S_FDECIDE;
      end
      ffa_pkg::S_FDECIDE: begin
        if (!st.merge_any && st.table_full) begin
          cm.set_status = 1'b1;
          cm.status = ffa_pkg::ST_FREEFUL;
          state_nxt = ffa_pkg::S_OUT;
        end else begin
          cm.free_apply = 1'b1;
          state_nxt = ffa_pkg::S_SHIFT;
        end
      end
      ffa_pkg::S_SHIFT: begin
        if (st.shift_done) begin
          state_nxt = ffa_pkg::S_COMMIT;
        end else begin
          cm.shift_step = 1'b1;
        end
      end
      ffa_pkg::S_COMMIT: begin
        cm.commit = 1'b1;
        cm.set_status = 1'b1;
        cm.status = ffa_pkg::ST_OK;
        state_nxt = ffa_pkg::S_OUT;
      end
      ffa_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = ffa_pkg::S_IDLE;
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_only_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cm.set_status))
    else $error("result raised without status");
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cm.load |-> !busy)
    else $error("item loaded while busy");
  a_commit_then_out: assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
    cm.commit |=> out_valid)
    else $error("commit not followed by result");
`endif

endmodule

@@ hw/rtl/ffa_dp.sv @@
// Datapath of the allocator: extent table, record table, totals and
// the fit / merge arithmetic. Depends on ffa_pkg.
module ffa_dp #(
  parameter int unsigned FREE_SLOTS   = ffa_pkg::FreeSlotsDef,
  parameter int unsigned LIVE_SLOTS   = ffa_pkg::LiveSlotsDef,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HeaderBytesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [ffa_pkg::AddrW-1:0]    cfg_wdata,
  input  logic                         in_cmd,
  input  logic [ffa_pkg::ReqW-1:0]     in_req_size,
  input  logic [2:0]                   in_align_log2,
  input  logic [ffa_pkg::AddrW-1:0]    in_free_address,
  input  ffa_pkg::cmd_t                cm,
  output ffa_pkg::stat_t               st,
  output logic [ffa_pkg::AddrW-1:0]    res_address,
  output logic [ffa_pkg::StatW-1:0]    res_status,
  output logic [ffa_pkg::LenW-1:0]     res_used,
  output logic [ffa_pkg::LiveW-1:0]    res_live
);

  localparam int unsigned AW  = ffa_pkg::AddrW;
  localparam int unsigned LW  = ffa_pkg::LenW;
  localparam int unsigned EIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned ECW = $clog2(FREE_SLOTS + 1);
  localparam int unsigned RIW = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
  localparam logic [LW-1:0] HDR = LW'(HEADER_BYTES);

  logic [AW-1:0]  ext_start_r [FREE_SLOTS];
  logic [LW-1:0]  ext_len_r   [FREE_SLOTS];
  logic [ECW-1:0] ext_cnt_r;
  logic [AW-1:0]  rec_addr_r  [LIVE_SLOTS];
  logic [LW-1:0]  rec_len_r   [LIVE_SLOTS];
  logic [7:0]     rec_pad_r   [LIVE_SLOTS];
  logic [LIVE_SLOTS-1:0] rec_valid_r;
  logic [LW-1:0]  used_r;
  logic [ffa_pkg::LiveW-1:0] live_r;
  logic [AW-1:0]  base_r;
  logic [LW-1:0]  size_r;

  logic           cmd_r;
  logic [ffa_pkg::ReqW-1:0] req_r;
  logic [2:0]     lg_r;
  logic [AW-1:0]  fa_r;
  logic [RIW:0]   rp_r;      // record pointer
  logic [ECW-1:0] ep_r;      // extent pointer
  logic [ECW-1:0] sp_r;      // shift pointer
  logic           shift_up_r, shift_dn_r;
  logic [ECW-1:0] shift_end_r;
  logic           fit_r;
  logic [LW-1:0]  adj_r, total_r;
  logic [AW-1:0]  bs_r;
  logic [LW-1:0]  sz_r;
  logic           mp_r, mn_r;
  logic [LW-1:0]  grant_len_r;
  logic [7:0]     grant_pad_r;
  logic [AW-1:0]  grant_addr_r;
  logic [AW-1:0]  addr_out_r;
  logic [ffa_pkg::StatW-1:0] stat_r;

  logic [RIW-1:0] ri;
  logic [EIW-1:0] ei, eim1;
  logic [AW-1:0]  cur_start, prv_start;
  logic [LW-1:0]  cur_len, prv_len;
  logic [7:0]     align, amask, adj0, need, adj;
  logic [LW:0]    total;
  logic [AW-1:0]  be;

  assign ri   = rp_r[RIW-1:0];
  assign ei   = ep_r[EIW-1:0];
  assign eim1 = EIW'(ep_r - ECW'(1));
  assign cur_start = ext_start_r[ei];
  assign cur_len   = ext_len_r[ei];
  assign prv_start = ext_start_r[eim1];
  assign prv_len   = ext_len_r[eim1];

  // Padding: align the address, then raise to at least the header size.
  always_comb begin
    align = 8'd1 << lg_r;
    amask = align - 8'd1;
    adj0  = (8'd0 - cur_start[7:0]) & amask;
    need  = 8'(HEADER_BYTES) - adj0;
    adj   = adj0;
    if (LW'(adj0) < HDR) begin
      adj = adj0 + (need & ~amask) + (((need & amask) != 8'd0) ? align : 8'd0);
    end
  end
  assign total = (LW+1)'(req_r) + (LW+1)'(adj);
  assign be = fa_r - AW'(rec_pad_r[ri]) + AW'(rec_len_r[ri]);

  always_comb begin
    st = '0;
    st.cmd        = cmd_r;
    st.req_zero   = (req_r == '0);
    st.rec_hit    = (cmd_r == ffa_pkg::CMD_ALLOC) ? !rec_valid_r[ri]
                    : (rec_valid_r[ri] && rec_addr_r[ri] == fa_r);
    st.rec_end    = (rp_r == (RIW+1)'(LIVE_SLOTS - 1));
    st.ext_end    = (ep_r >= ext_cnt_r) || (ep_r >= ECW'(FREE_SLOTS));
    st.fit        = fit_r;
    st.pos_stop   = (cur_start >= bs_r + AW'(sz_r));
    st.merge_any  = mp_r || mn_r;
    st.table_full = (ext_cnt_r >= ECW'(FREE_SLOTS));
    st.shift_done = !(shift_up_r || shift_dn_r) || (sp_r == shift_end_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      if (!rst_n) begin
        base_r <= '0;
        size_r <= LW'(24'hFFFFFF) + LW'(1);
      end else if (cfg_index == 1'b0) begin
        base_r <= cfg_wdata;
      end else begin
        size_r <= cfg_wdata[LW-1:0];
      end
      rec_valid_r <= '0;
      used_r      <= '0;
      live_r      <= '0;
      shift_up_r  <= 1'b0;
      shift_dn_r  <= 1'b0;
      stat_r      <= ffa_pkg::ST_OK;
      addr_out_r  <= '0;
      ep_r        <= '0;
      rp_r        <= '0;
      fit_r       <= 1'b0;
      mp_r        <= 1'b0;
      mn_r        <= 1'b0;
      sp_r        <= '0;
      shift_end_r <= '0;
      cmd_r       <= 1'b0;
      req_r       <= '0;
      lg_r        <= '0;
      fa_r        <= '0;
      bs_r        <= '0;
      sz_r        <= '0;
      adj_r       <= '0;
      total_r     <= '0;
      grant_len_r <= '0;
      grant_pad_r <= '0;
      grant_addr_r <= '0;
      // rebuild entry zero from the new register values
      ext_start_r[0] <= (!rst_n) ? '0 : ((cfg_index == 1'b0) ? cfg_wdata : base_r);
      ext_len_r[0]   <= (!rst_n) ? (LW'(24'hFFFFFF) + LW'(1))
                        : ((cfg_index == 1'b1) ? cfg_wdata[LW-1:0] : size_r);
      ext_cnt_r      <= (!rst_n) ? ECW'(1)
                        : (((cfg_index == 1'b1) ? cfg_wdata[LW-1:0] : size_r) != '0)
                          ? ECW'(1) : ECW'(0);
    end else begin
      if (cm.load) begin
        cmd_r <= in_cmd;
        req_r <= in_req_size;
        lg_r  <= in_align_log2;
        fa_r  <= in_free_address;
        rp_r  <= '0;
        ep_r  <= '0;
        shift_up_r <= 1'b0;
        shift_dn_r <= 1'b0;
        addr_out_r <= '0;
      end
      if (cm.rec_step) rp_r <= rp_r + (RIW+1)'(1);
      // capture the freed block once the record is found
      if (!cm.load && cmd_r == ffa_pkg::CMD_FREE && !cm.rec_step) begin
        bs_r <= fa_r - AW'(rec_pad_r[ri]);
        sz_r <= rec_len_r[ri];
      end
      if (cm.ext_step) ep_r <= ep_r + ECW'(1);
      if (cm.eval) begin
        fit_r   <= ({1'b0, cur_len} >= total);
        adj_r   <= LW'(adj);
        total_r <= total[LW-1:0];
        mp_r    <= (ep_r != '0) && (prv_start + AW'(prv_len) == bs_r);
        mn_r    <= (ep_r < ext_cnt_r) && (cur_start == be);
      end
      if (cm.alloc_take) begin
        grant_addr_r <= cur_start + AW'(adj_r);
        grant_pad_r  <= adj_r[7:0];
        if (cur_len - total_r <= HDR) begin
          grant_len_r <= cur_len;
          shift_dn_r  <= 1'b1;
          sp_r        <= ep_r;
          shift_end_r <= ext_cnt_r - ECW'(1);
          ext_cnt_r   <= ext_cnt_r - ECW'(1);
        end else begin
          grant_len_r <= total_r;
          ext_start_r[ei] <= cur_start + AW'(total_r);
          ext_len_r[ei]   <= cur_len - total_r;
        end
      end
      if (cm.free_apply) begin
        if (mp_r && mn_r) begin
          ext_len_r[eim1] <= prv_len + sz_r + cur_len;
          shift_dn_r  <= 1'b1;
          sp_r        <= ep_r;
          shift_end_r <= ext_cnt_r - ECW'(1);
          ext_cnt_r   <= ext_cnt_r - ECW'(1);
        end else if (mp_r) begin
          ext_len_r[eim1] <= prv_len + sz_r;
        end else if (mn_r) begin
          ext_start_r[ei] <= bs_r;
          ext_len_r[ei]   <= cur_len + sz_r;
        end else begin
          // open a gap at ep by moving entries up from the top
          shift_up_r  <= 1'b1;
          sp_r        <= ext_cnt_r;
          shift_end_r <= ep_r;
          ext_cnt_r   <= ext_cnt_r + ECW'(1);
        end
      end
      if (cm.shift_step) begin
        if (shift_dn_r) begin
          ext_start_r[sp_r[EIW-1:0]] <= ext_start_r[EIW'(sp_r + ECW'(1))];
          ext_len_r[sp_r[EIW-1:0]]   <= ext_len_r[EIW'(sp_r + ECW'(1))];
          sp_r <= sp_r + ECW'(1);
        end else begin
          ext_start_r[sp_r[EIW-1:0]] <= ext_start_r[EIW'(sp_r - ECW'(1))];
          ext_len_r[sp_r[EIW-1:0]]   <= ext_len_r[EIW'(sp_r - ECW'(1))];
          sp_r <= sp_r - ECW'(1);
        end
      end
      if (cm.commit) begin
        if (cmd_r == ffa_pkg::CMD_ALLOC) begin
          rec_valid_r[ri] <= 1'b1;
          rec_addr_r[ri]  <= grant_addr_r;
          rec_len_r[ri]   <= grant_len_r;
          rec_pad_r[ri]   <= grant_pad_r;
          used_r <= used_r + grant_len_r;
          live_r <= live_r + ffa_pkg::LiveW'(1);
          addr_out_r <= grant_addr_r;
        end else begin
          if (shift_up_r) begin
            ext_start_r[shift_end_r[EIW-1:0]] <= bs_r;
            ext_len_r[shift_end_r[EIW-1:0]]   <= sz_r;
          end
          rec_valid_r[ri] <= 1'b0;
          used_r <= used_r - sz_r;
          if (live_r != '0) live_r <= live_r - ffa_pkg::LiveW'(1);
        end
      end
      if (cm.set_status) stat_r <= cm.status;
    end
  end

  assign res_address = addr_out_r;
  assign res_status  = stat_r;
  assign res_used    = used_r;
  assign res_live    = live_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ext_cnt_r <= ECW'(FREE_SLOTS))
    else $error("extent count above capacity");
  a_shift_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    !(shift_up_r && shift_dn_r))
    else $error("shift in both directions");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_r != ffa_pkg::ST_OK) |-> (addr_out_r == '0))
    else $error("address on failure");
`endif

endmodule

@@ hw/rtl/first_fit_free_list_allocator.sv @@
// First-fit free-list allocator with coalescing over one address region.
// An item passes through these steps in order: accept, scan the record
// slots (up to LIVE_SLOTS), evaluate and check each extent tried for
// allocate or pass each extent for free, move extent entries one at a
// time when the table shrinks or grows, then set the status and present
// the result. The extent and record scans are sequential. One item is in
// work at a time; the result is held in an output register until taken.
// A configuration write rebuilds the tables.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
module first_fit_free_list_allocator #(
  parameter int unsigned FREE_SLOTS   = ffa_pkg::FreeSlotsDef,
  parameter int unsigned LIVE_SLOTS   = ffa_pkg::LiveSlotsDef,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // cmd
  input  logic [63:0] in_tdata,   // req_size[23:0], align_log2[2:0], free_address[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // address[31:0], status[2:0], used_bytes[24:0], live_count[4:0]
);

  ffa_pkg::cmd_t  cm;
  ffa_pkg::stat_t st;
  logic busy;
  logic [31:0] res_address;
  logic [2:0]  res_status;
  logic [24:0] res_used;
  logic [4:0]  res_live;

  assign in_tready = !busy;

  ffa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_tvalid && in_tready),
    .out_fire (out_tvalid && out_tready),
    .cfg_we,
    .st, .cm, .busy,
    .out_valid(out_tvalid)
  );

  ffa_dp #(
    .FREE_SLOTS(FREE_SLOTS), .LIVE_SLOTS(LIVE_SLOTS), .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_cmd          (in_tuser[0]),
    .in_req_size     (in_tdata[23:0]),
    .in_align_log2   (in_tdata[26:24]),
    .in_free_address (in_tdata[58:27]),
    .cm, .st,
    .res_address, .res_status, .res_used, .res_live
  );

  assign out_tdata = {7'd0, res_live, res_used, res_status, res_address};

endmodule

@@ dv/first_fit_free_list_allocator_test.sv @@
// Self-checking testbench for the first-fit free-list allocator.
// Holds a scoreboard class with its own copy of the extent and record tables.
// Depends on ffa_pkg and first_fit_free_list_allocator.
`timescale 1ns / 1ps

module first_fit_free_list_allocator_test;

  localparam int FS  = 16;
  localparam int LS  = 16;
  localparam int HDR = 8;

  typedef struct {
    logic [31:0] address;
    logic [2:0]  status;
    logic [24:0] used_bytes;
    logic [4:0]  live_count;
  } grant_t;

  class alloc_scoreboard;
    logic [31:0] ext_start[FS];
    logic [24:0] ext_len[FS];
    int          ext_cnt;
    logic [31:0] rec_addr[LS];
    logic [24:0] rec_len[LS];
    logic [7:0]  rec_pad[LS];
    bit          rec_valid[LS];
    logic [24:0] used;
    logic [4:0]  live;
    logic [31:0] region_base;
    logic [24:0] region_size;
    grant_t      grant_q[$];
    int          errors;

    function new();
      errors = 0;
      region_base = 32'd0;
      region_size = 25'd16777216;
      rebuild();
    endfunction

    function void rebuild();
      for (int k = 0; k < FS; k++) begin
        ext_start[k] = '0;
        ext_len[k] = '0;
      end
      for (int k = 0; k < LS; k++) begin
        rec_addr[k] = '0;
        rec_len[k] = '0;
        rec_pad[k] = '0;
        rec_valid[k] = 0;
      end
      ext_start[0] = region_base;
      ext_len[0] = region_size;
      ext_cnt = (region_size != 0) ? 1 : 0;
      used = '0;
      live = '0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
      if (idx == 0) region_base = val;
      else region_size = val[24:0];
      rebuild();
    endfunction

    function logic [31:0] padding(logic [31:0] b, logic [2:0] lg);
      logic [31:0] align, mask, adj, need;
      align = 32'd1 << lg;
      mask = align - 32'd1;
      adj = (32'd0 - b) & mask;
      if (adj < HDR) begin
        need = 32'(HDR) - adj;
        adj = adj + align * (need / align);
        if ((need & mask) != 0) adj = adj + align;
      end
      return adj;
    endfunction

    function void drop_extent(int i);
      for (int k = i; k + 1 < ext_cnt; k++) begin
        ext_start[k] = ext_start[k + 1];
        ext_len[k] = ext_len[k + 1];
      end
      ext_cnt--;
    endfunction

    function logic [2:0] grant(logic [23:0] req, logic [2:0] lg, output logic [31:0] addr);
      int r;
      logic [31:0] b, len, adj, total;
      addr = '0;
      if (req == 0) return ffa_pkg::ST_NOFIT;
      r = LS;
      for (int k = LS - 1; k >= 0; k--) if (!rec_valid[k]) r = k;
      if (r >= LS) return ffa_pkg::ST_RECFUL;
      for (int i = 0; i < ext_cnt; i++) begin
        b = ext_start[i];
        len = {7'd0, ext_len[i]};
        adj = padding(b, lg);
        total = {8'd0, req} + adj;
        if (len >= total) begin
          if (len - total <= HDR) begin
            total = len;
            drop_extent(i);
          end else begin
            ext_start[i] = b + total;
            ext_len[i] = 25'(len - total);
          end
          addr = b + adj;
          rec_addr[r] = addr;
          rec_len[r] = total[24:0];
          rec_pad[r] = adj[7:0];
          rec_valid[r] = 1;
          used = used + total[24:0];
          live = live + 5'd1;
          return ffa_pkg::ST_OK;
        end
      end
      return ffa_pkg::ST_NOFIT;
    endfunction

    function logic [2:0] release_block(logic [31:0] a);
      int r, i;
      logic [31:0] bs, sz, be;
      bit mp, mn;
      r = LS;
      for (int k = LS - 1; k >= 0; k--) if (rec_valid[k] && rec_addr[k] == a) r = k;
      if (r >= LS) return ffa_pkg::ST_UNKNOWN;
      bs = a - {24'd0, rec_pad[r]};
      sz = {7'd0, rec_len[r]};
      be = bs + sz;
      i = 0;
      while (i < ext_cnt && ext_start[i] < be) i++;
      mp = (i > 0) && (ext_start[i - 1] + {7'd0, ext_len[i - 1]} == bs);
      mn = (i < ext_cnt) && (ext_start[i] == be);
      if (mp && mn) begin
        ext_len[i - 1] = ext_len[i - 1] + sz[24:0] + ext_len[i];
        drop_extent(i);
      end else if (mp) begin
        ext_len[i - 1] = ext_len[i - 1] + sz[24:0];
      end else if (mn) begin
        ext_start[i] = bs;
        ext_len[i] = ext_len[i] + sz[24:0];
      end else begin
        if (ext_cnt >= FS) return ffa_pkg::ST_FREEFUL;
        for (int k = ext_cnt; k > i; k--) begin
          ext_start[k] = ext_start[k - 1];
          ext_len[k] = ext_len[k - 1];
        end
        ext_start[i] = bs;
        ext_len[i] = sz[24:0];
        ext_cnt++;
      end
      rec_valid[r] = 0;
      used = used - sz[24:0];
      if (live > 0) live = live - 5'd1;
      return ffa_pkg::ST_OK;
    endfunction

    function void note_item(logic c, logic [63:0] d);
      grant_t g;
      logic [31:0] a;
      a = '0;
      if (c == ffa_pkg::CMD_ALLOC) g.status = grant(d[23:0], d[26:24], a);
      else g.status = release_block(d[58:27]);
      g.address = (g.status == ffa_pkg::ST_OK) ? a : 32'd0;
      g.used_bytes = used;
      g.live_count = live;
      grant_q.push_back(g);
    endfunction

    function void check_result(logic [71:0] d);
      grant_t g;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      g = grant_q.pop_front();
      if (d[31:0] !== g.address) begin
        $display("%0t: address exp %h got %h", $realtime, g.address, d[31:0]);
        errors++;
      end
      if (d[34:32] !== g.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, g.status, d[34:32]);
        errors++;
      end
      if (d[59:35] !== g.used_bytes) begin
        $display("%0t: used_bytes exp %0d got %0d", $realtime, g.used_bytes, d[59:35]);
        errors++;
      end
      if (d[64:60] !== g.live_count) begin
        $display("%0t: live_count exp %0d got %0d", $realtime, g.live_count, d[64:60]);
        errors++;
      end
    endfunction

    // Address of a random live allocation, or a random word if none is live.
    function logic [31:0] live_address();
      int idx[$];
      for (int k = 0; k < LS; k++) if (rec_valid[k]) idx.push_back(k);
      if (idx.size() == 0) return $urandom;
      return rec_addr[idx[$urandom_range(idx.size() - 1)]];
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [0:0]  in_tuser = 0;   // cmd
  logic [63:0] in_tdata = 0;   // req_size[23:0], align_log2[2:0], free_address[31:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;      // address[31:0], status[2:0], used_bytes[24:0], live_count[4:0]

  alloc_scoreboard sb = new();
  int send_idle_pct = 37;
  int recv_idle_pct = 85;
  int hold_cycles = 0;

  first_fit_free_list_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic logic [63:0] pack_item(logic [23:0] req, logic [2:0] lg,
                                            logic [31:0] fa);
    return {5'd0, fa, lg, req};
  endfunction

  // Offer one item at the falling edge and hold it until accepted.
  task automatic send(logic c, logic [63:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(c, d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.grant_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_cfg(int idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx[0];
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic random_items(int n, int max_req);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        send(1'($urandom_range(1)), {$urandom, $urandom} & 64'h07FF_FFFF_FFFF_FFFF);
      end else if (roll < 62 && sb.live < LS) begin
        send(ffa_pkg::CMD_ALLOC,
             pack_item((roll < 58) ? 24'($urandom_range(max_req, 1)) : 24'($urandom),
                       3'($urandom), 32'd0));
      end else begin
        send(ffa_pkg::CMD_FREE, pack_item(24'($urandom), 3'($urandom), sb.live_address()));
      end
      if (k == n / 2 && send_idle_pct == 0) begin
        in_tvalid <= 1'b0;
        while (sb.grant_q.size() != 0) @(negedge clk);
      end
      if (k % 150 == 75) send_idle_pct = (send_idle_pct == 0) ? 0 : send_idle_pct;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, both commands and the special cases.
    send(ffa_pkg::CMD_ALLOC, pack_item(24'd0, 3'd0, 32'd0));
    send(ffa_pkg::CMD_ALLOC, pack_item(24'hFFFFFF, 3'd7, 32'd0));
    send(ffa_pkg::CMD_FREE, pack_item(24'd0, 3'd0, 32'hFFFFFFFF));
    for (int k = 0; k < 17; k++)
      send(ffa_pkg::CMD_ALLOC, pack_item(24'(1 + k * 37), k[2:0] ^ 3'd7, 32'd0));
    for (int k = 0; k < 5; k++)
      send(ffa_pkg::CMD_FREE, pack_item(24'hFFFFFF, 3'd7, sb.live_address()));

    write_cfg(0, 32'hFFFFFFF0);
    write_cfg(1, 32'd600);
    random_items(180, 48);

    // Long receiver hold-off while items keep coming.
    hold_cycles = 400;
    random_items(20, 48);

    send_idle_pct = 85;
    recv_idle_pct = 37;
    write_cfg(1, 32'd0);
    random_items(20, 16);
    write_cfg(0, $urandom);
    write_cfg(1, 32'd2048);
    random_items(200, 128);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(0, 32'd0);
    write_cfg(1, 32'd16777216);
    random_items(180, 4096);
    write_cfg(1, 32'd300);
    random_items(180, 24);

    in_tvalid <= 1'b0;
    drain();
    if (sb.errors == 0 && sb.grant_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
